### rtl/efp_pkg.sv
// Shared types and constants for the event frame parser.
// No dependencies; imported by efp_out_fifo and event_frame_parser.
`default_nettype none

package efp_pkg;

	// parse phases
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_HEAD = 3'd1;
	localparam logic [2:0] PH_SLEN = 3'd2;
	localparam logic [2:0] PH_SDAT = 3'd3;
	localparam logic [2:0] PH_PLEN = 3'd4;
	localparam logic [2:0] PH_PDAT = 3'd5;
	localparam logic [2:0] PH_TAIL = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_SESSION = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// summary status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SHORT     = 2'd1;
	localparam logic [1:0] ST_BAD_HDR   = 2'd2;
	localparam logic [1:0] ST_TRUNCATED = 2'd3;

	// header field values
	localparam logic [3:0] MSG_TYPE_A    = 4'h9;
	localparam logic [3:0] MSG_TYPE_B    = 4'hb;
	localparam logic [3:0] HDR_FLAGS     = 4'h4;
	localparam logic [3:0] HDR_NO_COMPR  = 4'h0;

	localparam int unsigned LEN_FIELD_BYTES = 4;

	// result queue
	localparam int unsigned EFP_FIFO_DEPTH = 4;
	localparam int unsigned EFP_PTR_W      = $clog2(EFP_FIFO_DEPTH);
	localparam int unsigned EFP_CNT_W      = $clog2(EFP_FIFO_DEPTH + 1);

	// byte position saturates; every header threshold is below 64
	localparam int unsigned POS_W = 7;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [31:0] event_number;
		logic [4:0]  event_code;
		logic [31:0] session_length;
		logic [31:0] payload_length;
		logic [1:0]  status;
		logic        run_last;
	} result_t;

	// dense renumbering of the known event ids
	function automatic logic [4:0] code_of(input logic [31:0] id);
		logic [4:0] code;
		case (id)
			32'd1:   code = 5'd1;
			32'd2:   code = 5'd2;
			32'd50:  code = 5'd3;
			32'd51:  code = 5'd4;
			32'd52:  code = 5'd5;
			32'd100: code = 5'd6;
			32'd101: code = 5'd7;
			32'd102: code = 5'd8;
			32'd150: code = 5'd9;
			32'd151: code = 5'd10;
			32'd152: code = 5'd11;
			32'd154: code = 5'd12;
			32'd200: code = 5'd13;
			32'd450: code = 5'd14;
			32'd451: code = 5'd15;
			32'd459: code = 5'd16;
			default: code = 5'd0;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

### rtl/efp_out_fifo.sv
// Result queue of the event frame parser: takes up to two results a cycle,
// hands out one unless head_stall is raised. Depends on efp_pkg.
`default_nettype none

module efp_out_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push0,
	input  wire efp_pkg::result_t push0_data,
	input  wire logic             push1,
	input  wire efp_pkg::result_t push1_data,
	output logic                  room,
	output logic                  head_valid,
	output efp_pkg::result_t      head_data,
	input  wire logic             head_stall
);
	import efp_pkg::*;

	result_t               mem_q [EFP_FIFO_DEPTH];
	logic [EFP_PTR_W-1:0]  wr_ptr_q;
	logic [EFP_PTR_W-1:0]  rd_ptr_q;
	logic [EFP_CNT_W-1:0]  count_q;
	logic                  pop;
	logic [1:0]            push_n;
	logic [EFP_PTR_W-1:0]  wr_ptr_1;

	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign pop        = head_valid && !head_stall;
	assign push_n     = {1'b0, push0} + {1'b0, push1};
	assign wr_ptr_1   = wr_ptr_q + EFP_PTR_W'(1);
	assign room       = (count_q <= EFP_CNT_W'(EFP_FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= push0_data;
		end
		if (push1) begin
			mem_q[wr_ptr_1] <= push1_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + EFP_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + EFP_PTR_W'(1);
			end
			count_q <= count_q + EFP_CNT_W'(push_n) - EFP_CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= EFP_CNT_W'(EFP_FIFO_DEPTH))
		else $error("result queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		EFP_PTR_W'(wr_ptr_q - rd_ptr_q) == EFP_PTR_W'(count_q))
		else $error("queue pointers disagree with count");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push0 || push1) |-> room)
		else $error("push into a queue without room for two results");

	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0)
		else $error("second push slot used without the first");

endmodule

`default_nettype wire

### rtl/event_frame_parser.sv
// Event frame parser top level: byte-wise header check, section tagging and
// frame summary. Depends on efp_pkg and efp_out_fifo.
//
// Takes one frame byte per clock while in_stall is low. Each request is
// parsed in the cycle it is accepted and its results (a tagged section
// byte, the frame summary, or both on a final byte that carries section
// data) are written into a four-entry result queue, whose registered head
// drives the output. While out_stall is low the output hands out one
// result per cycle, so a stream of frames sustains one byte per clock
// except that each frame_end byte adds one result; in_stall rises while
// the queue has fewer than two free entries. No pass after reset is needed.
`default_nettype none

module event_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       out_kind,
	output logic [7:0]       out_byte,
	output logic [31:0]      event_number,
	output logic [4:0]       event_code,
	output logic [31:0]      session_length,
	output logic [31:0]      payload_length,
	output logic [1:0]       status,
	output logic             run_last
);
	import efp_pkg::*;

	logic [2:0]        phase_q;
	logic [POS_W-1:0]  pos_q;
	logic [3:0]        hnib_q;
	logic [31:0]       event_q;
	logic [31:0]       acc_q;
	logic [31:0]       rem_q;
	logic [31:0]       ssz_q;
	logic [31:0]       psz_q;
	logic              herr_q;

	logic [2:0]        phase_d;
	logic [POS_W-1:0]  pos_d;
	logic [3:0]        hnib_d;
	logic [31:0]       event_d;
	logic [31:0]       acc_d;
	logic [31:0]       rem_d;
	logic [31:0]       ssz_d;
	logic [31:0]       psz_d;
	logic              herr_d;

	logic              accept;
	logic              room;
	logic              data_v;
	logic [1:0]        data_kind;
	logic [1:0]        st;
	logic [POS_W-1:0]  hbytes;
	logic [31:0]       acc_n;
	logic [31:0]       rem_n;
	result_t           data_res;
	result_t           sum_res;
	result_t           res0;
	result_t           res1;
	logic              push0;
	logic              push1;
	result_t           head;

	assign in_stall = !room;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		hnib_d    = hnib_q;
		event_d   = event_q;
		acc_d     = acc_q;
		rem_d     = rem_q;
		ssz_d     = ssz_q;
		psz_d     = psz_q;
		herr_d    = herr_q;
		data_v    = 1'b0;
		data_kind = KIND_SESSION;
		st        = ST_OK;

		// first byte of a frame: start from a clean state
		if (phase_q == PH_IDLE) begin
			event_d = '0;
			acc_d   = '0;
			rem_d   = '0;
			ssz_d   = '0;
			psz_d   = '0;
			herr_d  = 1'b0;
			hnib_d  = in_byte[3:0];
			phase_d = PH_HEAD;
		end

		hbytes = {1'b0, hnib_d, 2'b00};
		acc_n  = {acc_d[23:0], in_byte};
		rem_n  = rem_d - 32'd1;

		case (phase_d)
			PH_HEAD: begin
				if (pos_q == POS_W'(1)) begin
					if ((in_byte[7:4] != MSG_TYPE_A && in_byte[7:4] != MSG_TYPE_B)
							|| in_byte[3:0] != HDR_FLAGS) begin
						herr_d = 1'b1;
					end
				end else if (pos_q == POS_W'(2)) begin
					if (in_byte[3:0] != HDR_NO_COMPR) begin
						herr_d = 1'b1;
					end
				end
				if (pos_q >= hbytes && pos_q < hbytes + POS_W'(4)) begin
					event_d = {event_d[23:0], in_byte};
				end
				if (pos_q == hbytes + POS_W'(3)) begin
					phase_d = PH_SLEN;
					rem_d   = 32'(LEN_FIELD_BYTES);
					acc_d   = '0;
				end
			end
			PH_SLEN, PH_PLEN: begin
				acc_d = acc_n;
				if (rem_n == '0) begin
					rem_d = acc_n;
					if (phase_d == PH_SLEN) begin
						ssz_d = acc_n;
						if (acc_n == '0) begin
							phase_d = PH_PLEN;
							rem_d   = 32'(LEN_FIELD_BYTES);
							acc_d   = '0;
						end else begin
							phase_d = PH_SDAT;
						end
					end else begin
						psz_d   = acc_n;
						phase_d = (acc_n == '0) ? PH_TAIL : PH_PDAT;
					end
				end else begin
					rem_d = rem_n;
				end
			end
			PH_SDAT, PH_PDAT: begin
				data_v    = !herr_d;
				data_kind = (phase_d == PH_SDAT) ? KIND_SESSION : KIND_PAYLOAD;
				rem_d     = rem_n;
				if (rem_n == '0) begin
					if (phase_d == PH_SDAT) begin
						phase_d = PH_PLEN;
						rem_d   = 32'(LEN_FIELD_BYTES);
						acc_d   = '0;
					end else begin
						phase_d = PH_TAIL;
					end
				end
			end
			default: begin
			end
		endcase

		if (pos_q != '1) begin
			pos_d = pos_q + POS_W'(1);
		end

		if (pos_q < POS_W'(3)) begin
			st = ST_SHORT;
		end else if (herr_d) begin
			st = ST_BAD_HDR;
		end else if (phase_d == PH_HEAD) begin
			st = ST_SHORT;
		end else if (phase_d == PH_SDAT || phase_d == PH_PDAT) begin
			st = ST_TRUNCATED;
		end else begin
			st = ST_OK;
		end

		if (frame_end) begin
			phase_d = PH_IDLE;
			pos_d   = '0;
		end
	end

	always_comb begin
		data_res          = '0;
		data_res.kind     = data_kind;
		data_res.data     = in_byte;
		data_res.run_last = !frame_end;

		sum_res          = '0;
		sum_res.kind     = KIND_SUMMARY;
		sum_res.status   = st;
		sum_res.run_last = 1'b1;
		if (st == ST_OK || st == ST_TRUNCATED) begin
			sum_res.event_number   = event_d;
			sum_res.event_code     = code_of(event_d);
			sum_res.session_length = ssz_d;
			sum_res.payload_length = psz_d;
		end

		if (data_v) begin
			res0  = data_res;
			res1  = sum_res;
			push0 = accept;
			push1 = accept && frame_end;
		end else begin
			res0  = sum_res;
			res1  = sum_res;
			push0 = accept && frame_end;
			push1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			hnib_q  <= '0;
			event_q <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			ssz_q   <= '0;
			psz_q   <= '0;
			herr_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			hnib_q  <= hnib_d;
			event_q <= event_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			ssz_q   <= ssz_d;
			psz_q   <= psz_d;
			herr_q  <= herr_d;
		end
	end

	efp_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push0      (push0),
		.push0_data (res0),
		.push1      (push1),
		.push1_data (res1),
		.room       (room),
		.head_valid (out_valid),
		.head_data  (head),
		.head_stall (out_stall)
	);

	assign out_kind       = head.kind;
	assign out_byte       = head.data;
	assign event_number   = head.event_number;
	assign event_code     = head.event_code;
	assign session_length = head.session_length;
	assign payload_length = head.payload_length;
	assign status         = head.status;
	assign run_last       = head.run_last;

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame_end) |=> (phase_q == PH_IDLE && pos_q == '0))
		else $error("frame end did not return the parser to idle");

	a_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (pos_q == '0))
		else $error("idle parser with a nonzero byte position");

	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SDAT || phase_q == PH_PDAT) |-> (rem_q != '0))
		else $error("section data phase with no bytes remaining");

	a_len_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SLEN || phase_q == PH_PLEN)
			|-> (rem_q != '0 && rem_q <= 32'(LEN_FIELD_BYTES)))
		else $error("length field byte count out of range");

endmodule

`default_nettype wire

### tb/sv/tb_event_frame_parser.sv
// Self-checking testbench for event_frame_parser: frame bytes in, tagged section bytes
// and frame summaries out, checked against a behavioral predictor of the parser.
// Depends on efp_pkg and the event_frame_parser RTL.
`default_nettype none

module tb_event_frame_parser;
	import efp_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 100;
	localparam int DRAIN_CYCLES = 8;

	// index i holds the id that maps to event code i+1
	localparam logic [15:0][31:0] KNOWN_IDS = {
		32'd459, 32'd451, 32'd450, 32'd200, 32'd154, 32'd152, 32'd151, 32'd150,
		32'd102, 32'd101, 32'd100, 32'd52,  32'd51,  32'd50,  32'd2,   32'd1
	};

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  in_byte = 8'h00;
	logic        frame_end = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic [31:0] event_number;
	logic [4:0]  event_code;
	logic [31:0] session_length;
	logic [31:0] payload_length;
	logic [1:0]  status;
	logic        run_last;

	event_frame_parser uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.frame_end      (frame_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_kind       (out_kind),
		.out_byte       (out_byte),
		.event_number   (event_number),
		.event_code     (event_code),
		.session_length (session_length),
		.payload_length (payload_length),
		.status         (status),
		.run_last       (run_last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// parser state as predicted
	logic [2:0]  parse_phase = PH_IDLE;
	logic [31:0] byte_pos = '0;
	logic [31:0] hdr_len = '0;
	logic [31:0] ev_word = '0;
	logic [31:0] len_acc = '0;
	logic [31:0] remaining = '0;
	logic [31:0] sess_size = '0;
	logic [31:0] pay_size = '0;
	logic        hdr_bad = 1'b0;

	result_t     awaited_results[$];
	logic [7:0]  frame_q[$];
	int          err_count = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;

	// sender and receiver idling controls
	bit          gaps_on = 1'b0;
	bit          offering = 1'b0;
	int          burst_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	logic [15:0] stall_pat = 16'h0;
	logic [3:0]  pat_idx = 4'h0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	task automatic queue_result(input result_t r);
		awaited_results.insert(awaited_results.size(), r);
	endtask

	task automatic add_byte(input logic [7:0] b);
		frame_q.insert(frame_q.size(), b);
	endtask

	function automatic logic [4:0] event_code_for(input logic [31:0] id);
		logic [4:0] code;
		code = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (KNOWN_IDS[i] == id)
				code = 5'(i + 1);
		end
		return code;
	endfunction

	// advance the predicted parser by one accepted request
	task automatic predict_parse(input logic [7:0] b, input logic last);
		logic [31:0] p;
		logic [1:0]  st;
		result_t     r;
		p = byte_pos;
		if (parse_phase == PH_IDLE) begin
			byte_pos  = '0;
			ev_word   = '0;
			len_acc   = '0;
			remaining = '0;
			sess_size = '0;
			pay_size  = '0;
			hdr_bad   = 1'b0;
			hdr_len   = {26'd0, b[3:0], 2'b00};
			parse_phase = PH_HEAD;
		end
		case (parse_phase)
			PH_HEAD: begin
				if (p == 1) begin
					if ((b[7:4] != MSG_TYPE_A && b[7:4] != MSG_TYPE_B) || b[3:0] != HDR_FLAGS)
						hdr_bad = 1'b1;
				end else if (p == 2) begin
					if (b[3:0] != HDR_NO_COMPR)
						hdr_bad = 1'b1;
				end
				// a header shorter than four bytes overlaps the event id
				if (p >= hdr_len && p < hdr_len + 4)
					ev_word = {ev_word[23:0], b};
				if (p == hdr_len + 3) begin
					parse_phase = PH_SLEN;
					remaining = LEN_FIELD_BYTES;
					len_acc = '0;
				end
			end
			PH_SLEN, PH_PLEN: begin
				len_acc = {len_acc[23:0], b};
				remaining = remaining - 1;
				if (remaining == 0) begin
					remaining = len_acc;
					if (parse_phase == PH_SLEN) begin
						sess_size = len_acc;
						if (len_acc == 0) begin
							parse_phase = PH_PLEN;
							remaining = LEN_FIELD_BYTES;
							len_acc = '0;
						end else begin
							parse_phase = PH_SDAT;
						end
					end else begin
						pay_size = len_acc;
						parse_phase = (len_acc == 0) ? PH_TAIL : PH_PDAT;
					end
				end
			end
			PH_SDAT, PH_PDAT: begin
				if (!hdr_bad) begin
					r = '0;
					r.kind = (parse_phase == PH_SDAT) ? KIND_SESSION : KIND_PAYLOAD;
					r.data = b;
					r.run_last = !last;
					queue_result(r);
				end
				remaining = remaining - 1;
				if (remaining == 0) begin
					if (parse_phase == PH_SDAT) begin
						parse_phase = PH_PLEN;
						remaining = LEN_FIELD_BYTES;
						len_acc = '0;
					end else begin
						parse_phase = PH_TAIL;
					end
				end
			end
			default: ;
		endcase
		if (byte_pos != 32'hFFFF_FFFF)
			byte_pos = byte_pos + 1;
		if (last) begin
			if (p < 3)
				st = ST_SHORT;
			else if (hdr_bad)
				st = ST_BAD_HDR;
			else if (parse_phase == PH_HEAD)
				st = ST_SHORT;
			else if (parse_phase == PH_SDAT || parse_phase == PH_PDAT)
				st = ST_TRUNCATED;
			else
				st = ST_OK;
			r = '0;
			r.kind = KIND_SUMMARY;
			if (st == ST_OK || st == ST_TRUNCATED) begin
				r.event_number   = ev_word;
				r.event_code     = event_code_for(ev_word);
				r.session_length = sess_size;
				r.payload_length = pay_size;
			end
			r.status = st;
			r.run_last = 1'b1;
			queue_result(r);
			parse_phase = PH_IDLE;
			byte_pos = '0;
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				report("result with none pending, kind", 32'(out_kind), 32'd0);
			end else begin
				want = awaited_results.pop_front();
				if (out_kind !== want.kind)
					report("out_kind", 32'(out_kind), 32'(want.kind));
				if (out_byte !== want.data)
					report("out_byte", 32'(out_byte), 32'(want.data));
				if (event_number !== want.event_number)
					report("event_number", event_number, want.event_number);
				if (event_code !== want.event_code)
					report("event_code", 32'(event_code), 32'(want.event_code));
				if (session_length !== want.session_length)
					report("session_length", session_length, want.session_length);
				if (payload_length !== want.payload_length)
					report("payload_length", payload_length, want.payload_length);
				if (status !== want.status)
					report("status", 32'(status), 32'(want.status));
				if (run_last !== want.run_last)
					report("run_last", 32'(run_last), 32'(want.run_last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: long hold on request, otherwise the current stall mode
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_PATTERN: begin
					out_stall <= stall_pat[pat_idx];
					pat_idx = pat_idx + 4'd1;
				end
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last);
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				if (offering) begin
					in_valid <= 1'b0;
					offering = 1'b0;
				end
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(7, 15)) @(posedge clk);
				else
					repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		offering = 1'b1;
		in_byte <= b;
		frame_end <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_parse(b, last);
		items_sent++;
	endtask

	task automatic stop_sending();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_item(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic shuffle_idling();
		int pick;
		gaps_on = ($urandom_range(0, 3) != 0);
		pick = $urandom_range(0, 2);
		stall_mode = (pick == 0) ? STALL_NONE : (pick == 1) ? STALL_RANDOM : STALL_PATTERN;
		stall_pat = 16'($urandom);
	endtask

	// length field plus data; a huge length gets only a few data bytes
	task automatic add_section(output bit cut_short);
		logic [31:0] len;
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			len = '0;
		else if (r < 90)
			len = $urandom_range(1, 6);
		else if (r < 97)
			len = $urandom | 32'h40;
		else
			len = 32'hFFFF_FFFF;
		for (int k = 3; k >= 0; k--)
			add_byte(len[8*k +: 8]);
		cut_short = (len >= 32'h40);
		if (cut_short)
			len = $urandom_range(0, 3);
		for (int k = 0; k < len; k++)
			add_byte(8'($urandom));
	endtask

	task automatic make_frame(input bit bad_header, input bit force_cut);
		logic [3:0]  hsize, nib;
		logic [7:0]  b1, b2, rnd;
		logic [31:0] id;
		bit          cut_short;
		int          r, cut;
		frame_q.delete();
		if ($urandom_range(0, 7) == 0)
			hsize = 4'($urandom_range(4, 15));
		else
			hsize = 4'($urandom_range(0, 3));
		nib = 4'($urandom);
		add_byte({nib, hsize});
		b1 = {($urandom_range(0, 1) ? MSG_TYPE_A : MSG_TYPE_B), HDR_FLAGS};
		nib = 4'($urandom);
		b2 = {nib, HDR_NO_COMPR};
		if (bad_header) begin
			nib = 4'($urandom);
			case ($urandom_range(0, 2))
				0: begin
					if (nib == MSG_TYPE_A || nib == MSG_TYPE_B)
						nib = 4'h0;
					b1 = {nib, HDR_FLAGS};
				end
				1: begin
					if (nib == HDR_FLAGS)
						nib = 4'h5;
					b1 = {MSG_TYPE_B, nib};
				end
				default: begin
					if (nib == HDR_NO_COMPR)
						nib = 4'h1;
					b2 = {b2[7:4], nib};
				end
			endcase
		end
		add_byte(b1);
		add_byte(b2);
		rnd = 8'($urandom);
		add_byte(rnd);
		for (int k = 4; k < 4 * hsize; k++)
			add_byte(8'($urandom));
		if (hsize != 0) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				id = KNOWN_IDS[$urandom_range(0, 15)];
			else if (r == 5)
				id = '0;
			else if (r == 6)
				id = '1;
			else
				id = $urandom;
			for (int k = 3; k >= 0; k--)
				add_byte(id[8*k +: 8]);
		end
		add_section(cut_short);
		if (!cut_short) begin
			add_section(cut_short);
			// trailing bytes after the payload are ignored by the parser
			if (!cut_short && $urandom_range(0, 9) < 3)
				repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
		end
		if (force_cut || $urandom_range(0, 4) == 0) begin
			cut = $urandom_range(1, frame_q.size());
			while (frame_q.size() > cut)
				void'(frame_q.pop_back());
		end
	endtask

	task automatic make_noise();
		frame_q.delete();
		repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
	endtask

	task automatic test_directed();
		gaps_on = 1'b0;
		stall_mode = STALL_PATTERN;
		stall_pat = 16'h5A3C;
		// single byte frame
		frame_q = '{8'hFF};
		send_frame();
		// wrong type and compression, frame ends on the last header byte
		frame_q = '{8'h01, 8'h54, 8'h0F, 8'h00};
		send_frame();
		// zero-size header, one session byte, payload length cut off
		frame_q = '{8'h00, 8'hB4, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF,
			8'h00, 8'h00};
		send_frame();
		// empty session, huge payload truncated after one byte
		frame_q = '{8'h00, 8'h94, 8'hF0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A};
		send_frame();
		stop_sending();
		wait_drained();
	endtask

	task automatic test_random_frames();
		int target, frames, r;
		target = items_sent + 1000;
		frames = 0;
		while (items_sent < target) begin
			if (frames % 16 == 0)
				shuffle_idling();
			r = $urandom_range(0, 99);
			if (r < 8)
				make_noise();
			else
				make_frame(r < 16, 1'b0);
			send_frame();
			if ($urandom_range(0, 29) == 0) begin
				stop_sending();
				wait_drained();
			end
			frames++;
		end
		stop_sending();
		wait_drained();
	endtask

	task automatic test_broken_frames();
		int target;
		target = items_sent + 200;
		shuffle_idling();
		while (items_sent < target) begin
			if ($urandom_range(0, 1))
				make_noise();
			else
				make_frame($urandom_range(0, 1), 1'b1);
			send_frame();
		end
		stop_sending();
		wait_drained();
	endtask

	// receiver holds off long enough for the result queue to fill and stall input
	task automatic test_backpressure();
		gaps_on = 1'b0;
		stall_mode = STALL_NONE;
		hold_req = 1'b1;
		repeat (4) begin
			make_frame(1'b0, 1'b0);
			send_frame();
		end
		stop_sending();
		wait_drained();
	endtask

	task automatic test_full_rate();
		int target;
		target = items_sent + 150;
		gaps_on = 1'b0;
		stall_mode = STALL_NONE;
		while (items_sent < target) begin
			make_frame(1'b0, 1'b0);
			send_frame();
		end
		stop_sending();
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_frames();
		test_broken_frames();
		test_backpressure();
		test_full_rate();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
rtl/efp_pkg.sv
rtl/efp_out_fifo.sv
rtl/event_frame_parser.sv
tb/sv/tb_event_frame_parser.sv
